// ===== src/b32_pkg.sv =====
// Shared types, constants and the alphabet decode for the base32 symbol decoder.
// No dependencies.
package b32_pkg;

  localparam int unsigned SymBits  = 5;
  localparam int unsigned ByteBits = 8;
  localparam int unsigned PendBits = 7;
  localparam int unsigned CntBits  = 3;
  localparam int unsigned AccBits  = PendBits + SymBits;

  // Carried from one character to the next within a string.
  typedef struct packed {
    logic [PendBits-1:0] pend_bits;
    logic [CntBits-1:0]  pend_cnt;
    logic                err;
  } state_t;

  // One result beat.
  typedef struct packed {
    logic [ByteBits-1:0] data_byte;
    logic                byte_valid;
    logic                end_of_string;
    logic                status;
  } result_t;

  typedef struct packed {
    logic               ok;
    logic [SymBits-1:0] value;
  } sym_t;

  // 0-9, A-H, J-N, P, R-Y map to 0..31; anything else is invalid.
  function automatic sym_t symbol_value(input logic [7:0] c);
    sym_t s;
    s.ok    = 1'b1;
    s.value = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      s.value = SymBits'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h48) begin
      s.value = SymBits'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h4a && c <= 8'h4e) begin
      s.value = SymBits'(c - 8'h4a + 8'd18);
    end else if (c == 8'h50) begin
      s.value = SymBits'(8'd23);
    end else if (c >= 8'h52 && c <= 8'h59) begin
      s.value = SymBits'(c - 8'h52 + 8'd24);
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== src/b32_step.sv =====
// Combinational per-character step: decode, accumulate, emit byte, end check.
// Depends on b32_pkg.
module b32_step (
  input  logic [7:0]      symbol,
  input  logic            last,
  input  b32_pkg::state_t st,
  output b32_pkg::state_t st_nxt,
  output b32_pkg::result_t res
);

  b32_pkg::sym_t                 sym;
  logic                          err;
  logic [b32_pkg::AccBits-1:0]   acc;
  logic [b32_pkg::AccBits-1:0]   acc_sh;
  logic [b32_pkg::AccBits-1:0]   acc_mask;
  logic [b32_pkg::CntBits:0]     cnt;
  logic [b32_pkg::CntBits:0]     cnt_left;
  logic                          emit;
  b32_pkg::state_t               upd;

  always_comb begin
    sym      = b32_pkg::symbol_value(symbol);
    err      = st.err | ~sym.ok;
    acc      = {st.pend_bits, sym.value};
    cnt      = {1'b0, st.pend_cnt} + (b32_pkg::CntBits+1)'(b32_pkg::SymBits);
    emit     = cnt >= (b32_pkg::CntBits+1)'(b32_pkg::ByteBits);
    cnt_left = emit ? cnt - (b32_pkg::CntBits+1)'(b32_pkg::ByteBits) : cnt;
    acc_sh   = acc >> cnt_left;
    acc_mask = ~({b32_pkg::AccBits{1'b1}} << cnt_left);

    // Accumulator freezes once an invalid character has been seen.
    upd = st;
    upd.err = err;
    if (!err) begin
      upd.pend_bits = b32_pkg::PendBits'(emit ? (acc & acc_mask) : acc);
      upd.pend_cnt  = cnt_left[b32_pkg::CntBits-1:0];
    end

    res.byte_valid    = ~err & emit;
    res.data_byte     = res.byte_valid ? acc_sh[b32_pkg::ByteBits-1:0] : '0;
    res.end_of_string = last;
    res.status        = last & (upd.err
                        | (upd.pend_cnt >= b32_pkg::CntBits'(b32_pkg::SymBits))
                        | (upd.pend_bits != '0));

    st_nxt = last ? '0 : upd;
  end

endmodule

// ===== src/base32_symbol_decoder.sv =====
// Top level of the base32 symbol decoder: input register, step logic, result register.
// Depends on b32_pkg and b32_step.
//
// Usage:
//   Input stream: one ASCII character per beat on in_tdata, in_tlast high on
//   the final character of a string. Alphabet 0-9, A-Y without I, O, Q, Z.
//   Output stream: exactly one beat per input beat. out_tdata carries the
//   decoded byte (zero when none), out_tuser[0] flags a byte present,
//   out_tuser[1] is the string status (1 = invalid character or bad
//   padding) and is only set on the out_tlast beat.
//   Path: an accepted character waits in the input register, then moves
//   into the result register once that register is free.
//   Throughput: 1 character per cycle while out_tready is high; the only
//   loop is the accumulator state, updated in the same cycle a character
//   moves into the result register.
//   Stall: when out_tready is low the result register holds its beat, the
//   input register fills, and in_tready then drops until the result drains.
//   Reset: synchronous active-low rst_n clears both valid flags and the
//   accumulator, bit count and sticky error, so decoding starts on a fresh
//   string.
module base32_symbol_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic [1:0] out_tuser,  // [0] byte_valid, [1] status
  output logic       out_tlast
);

  // Input stage
  logic            in_vld_r;
  logic [7:0]      sym_r;
  logic            last_r;

  // String state
  b32_pkg::state_t state_r;
  b32_pkg::state_t state_nxt;

  // Result stage
  logic             out_vld_r;
  b32_pkg::result_t res_r;
  b32_pkg::result_t res_nxt;

  logic advance;

  // Move the held character into the result register when it is free.
  assign advance   = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | advance;

  b32_step u_step (
    .symbol (sym_r),
    .last   (last_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sym_r  <= in_tdata;
      last_r <= in_tlast;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r.data_byte;
  assign out_tuser  = {res_r.status, res_r.byte_valid};
  assign out_tlast  = res_r.end_of_string;

endmodule

// ===== src/b32_checker.sv =====
// Port-level checks for base32_symbol_decoder, bound to the top level.
// Depends on base32_symbol_decoder.
module b32_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // Status only rides on the closing beat of a string.
  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("status set on a beat without tlast");

  // No byte flagged means the data field is zero.
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 8'h00)
    else $error("nonzero data on a beat without a byte");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Nothing valid right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind base32_symbol_decoder b32_checker u_b32_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== dv/tb_b32_check_pkg.sv =====
// Scoreboard for the base32 symbol decoder: predicts one result beat per character.
// Depends on b32_pkg for the result beat layout.
package tb_b32_check_pkg;

  // Symbol values 0..31 in alphabet order.
  localparam string B32_ALPHABET = "0123456789ABCDEFGHJKLMNPRSTUVWXY";

  function automatic logic [7:0] b32_char(input logic [4:0] value);
    return B32_ALPHABET[value];
  endfunction

  class b32_decode_check;
    logic [6:0] pend_bits;
    logic [2:0] pend_cnt;
    logic       err;
    b32_pkg::result_t expected_beats[$];
    int unsigned fails;
    int unsigned beats_checked;
    int unsigned strings_seen;
    int unsigned bytes_seen;
    int unsigned bad_strings;

    function new();
      pend_bits = '0;
      pend_cnt  = '0;
      err       = 1'b0;
      fails     = 0;
      beats_checked = 0;
      strings_seen  = 0;
      bytes_seen    = 0;
      bad_strings   = 0;
    endfunction

    function bit lookup(input logic [7:0] sym, output logic [4:0] value);
      value = '0;
      for (int i = 0; i < 32; i++) begin
        if (B32_ALPHABET[i] == sym) begin
          value = 5'(i);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Accepted input beat: advance the accumulator and queue the expected result.
    function void note_char(input logic [7:0] sym, input logic last);
      b32_pkg::result_t r;
      logic [4:0]  v;
      logic [11:0] acc;
      logic [3:0]  cnt;
      r = '0;
      if (!lookup(sym, v)) err = 1'b1;
      if (!err) begin
        acc = {pend_bits, v};
        cnt = {1'b0, pend_cnt} + 4'd5;
        if (cnt >= 4'd8) begin
          cnt         = cnt - 4'd8;
          r.data_byte  = 8'(acc >> cnt);
          r.byte_valid = 1'b1;
          acc          = acc & ((12'd1 << cnt) - 12'd1);
        end
        pend_bits = acc[6:0];
        pend_cnt  = cnt[2:0];
      end
      if (last) begin
        r.end_of_string = 1'b1;
        r.status = err || (pend_cnt >= 3'd5) || (pend_bits != 7'd0);
        pend_bits = '0;
        pend_cnt  = '0;
        err       = 1'b0;
      end
      expected_beats.push_back(r);
    endfunction

    function void compare(input string field, input longint unsigned stamp,
                          input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
        $display("%0d ns: %s mismatch: expected %0h, actual %0h", stamp, field, want, got);
        fails++;
      end
    endfunction

    // Accepted result beat: compare against the oldest expectation.
    function void check_beat(input longint unsigned stamp, input logic [7:0] data,
                             input logic [1:0] user, input logic tlast);
      b32_pkg::result_t want;
      if (expected_beats.size() == 0) begin
        $display("%0d ns: unexpected result beat: expected none, actual data=%0h user=%b last=%b",
                 stamp, data, user, tlast);
        fails++;
        return;
      end
      want = expected_beats.pop_front();
      compare("data_byte", stamp, want.data_byte, data);
      compare("byte_valid", stamp, 8'(want.byte_valid), 8'(user[0]));
      compare("status", stamp, 8'(want.status), 8'(user[1]));
      compare("end_of_string", stamp, 8'(want.end_of_string), 8'(tlast));
      beats_checked++;
      if (want.byte_valid) bytes_seen++;
      if (want.end_of_string) begin
        strings_seen++;
        if (want.status) bad_strings++;
      end
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
// Top-level testbench for base32_symbol_decoder: clock, reset, stream drivers, watchdog.
// Depends on b32_pkg, tb_b32_check_pkg and the decoder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS  = 1000;
  localparam int unsigned CALM_AFTER    = 850;   // no idling past this many random beats
  localparam int unsigned HOLD_AT_BEAT  = 300;   // long output stall starts here
  localparam int unsigned HOLD_CYCLES   = 60;
  localparam int unsigned WATCHDOG_MAX  = 2000;
  localparam int unsigned DRAIN_CYCLES  = 8;     // margin after the last expected result beat

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] symbol
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] data_byte
  logic [1:0] out_tuser;  // [0] byte_valid, [1] status
  logic       out_tlast;

  tb_b32_check_pkg::b32_decode_check sb;
  bit          idle_on;
  int unsigned random_items;
  int unsigned idle_cycles;

  base32_symbol_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one character, optionally after a short gap, and hold it until accepted.
  // tready is sampled right after the edge, i.e. the value the DUT saw at the edge.
  task automatic send_char(input logic [7:0] sym, input logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_char(sym, last);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Mostly well-formed strings (legal length, zero padding); the rest are strings
  // with arbitrary padding or an injected bad character, and raw byte noise.
  task automatic send_random_string();
    int unsigned kind;
    int unsigned len;
    int unsigned pad;
    int unsigned bad_pos;
    logic [4:0]  v;
    logic [7:0]  sym;
    kind    = $urandom_range(0, 99);
    len     = $urandom_range(1, 16);
    if (kind < 70) begin
      while (((len * 5) % 8) >= 5) len = $urandom_range(1, 16);
    end
    pad     = (len * 5) % 8;
    bad_pos = (kind >= 80 && kind < 85) ? $urandom_range(0, len - 1) : len;
    for (int unsigned i = 0; i < len; i++) begin
      v = 5'($urandom_range(0, 31));
      // leftover bits all come from the final character; clear them
      if (kind < 70 && i == len - 1) v = v & ~5'((1 << pad) - 1);
      if (kind >= 85) sym = 8'($urandom_range(0, 255));
      else if (i == bad_pos) sym = 8'($urandom_range(0, 255)) | 8'h80;
      else sym = tb_b32_check_pkg::b32_char(v);
      send_char(sym, i == len - 1);
    end
    random_items += len;
  endtask

  // Receiver: random short stalls, one long hold-off so the pipeline backs up.
  initial begin : receiver
    int unsigned stall_left;
    bit          held;
    stall_left = 0;
    held       = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_beat($time, out_tdata, out_tuser, out_tlast);
      end
      if (!held && sb.beats_checked >= HOLD_AT_BEAT) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles in a row with no beat on either side.
  initial begin : watchdog
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("%0t: watchdog expired with %0d beats outstanding", $time, sb.pending());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : main
    sb           = new();
    idle_on      = 1'b1;
    random_items = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases
    send_string("00");        // clean two-char string, byte on last char
    send_string("YY");        // all-ones byte, nonzero leftover padding
    send_string("Y");         // five bits left over
    send_string("0I0");       // excluded letter mid-string, error is sticky
    send_string("00Z");       // invalid character on the last beat
    send_string("a0");        // lower case is rejected
    send_char(8'h00, 1'b0);   // symbol extremes
    send_char(8'hff, 1'b0);
    send_char("0", 1'b1);
    send_string("ABCDEFGH");  // 40 bits: five bytes, zero leftover

    // Random strings
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= CALM_AFTER) idle_on = 1'b0;
      send_random_string();
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result beats over %0d strings: %0d bytes decoded, %0d strings bad.",
             sb.beats_checked, sb.strings_seen, sb.bytes_seen, sb.bad_strings);
    $display("Stimulus: directed corner strings, random well-formed, malformed and noise input.");
    if (sb.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
